// ===== hw/rtl/lwt_pkg.sv =====
// lwt_pkg: record type and fixed constants shared by the tokenizer modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lwt_pkg;

	// fixed field widths of one result item
	localparam int LINE_BITS = 24;
	localparam int WNUM_BITS = 16;
	localparam int OFS_BITS  = 24;

	// record kinds
	localparam logic REC_LINE = 1'b0;
	localparam logic REC_WORD = 1'b1;

	// result queue depth, a power of two
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// most records one byte can give
	localparam int MAX_RECS = 3;

	// one result item
	typedef struct packed {
		logic                 kind;
		logic [LINE_BITS-1:0] line_number;
		logic [WNUM_BITS-1:0] word_number;
		logic [OFS_BITS-1:0]  start_offset;
		logic [OFS_BITS-1:0]  byte_length;
		logic                 run_last;
		logic                 data_end;
	} rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lwt_core.sv =====
// lwt_core: per-byte classification, tokenizer state and record building
// depends on lwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lwt_core #(
	parameter int OFFSET_BITS     = 24,
	parameter int WORD_COUNT_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	input  wire logic         split_mode,
	output logic [1:0]        rec_cnt,
	output lwt_pkg::rec_t     recs [lwt_pkg::MAX_RECS]
);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [WORD_COUNT_BITS-1:0] WCNT_MAX = '1;

	typedef enum logic [1:0] {
		BRK_NONE = 2'd0,
		BRK_CR   = 2'd1,
		BRK_LF   = 2'd2
	} brk_t;

	// offset resized to the output field width
	function automatic logic [lwt_pkg::OFS_BITS-1:0] ofs_out(
		input logic [OFFSET_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[lwt_pkg::OFS_BITS-1:0];
	endfunction

	// word count resized to the output field width
	function automatic logic [lwt_pkg::WNUM_BITS-1:0] wcnt_out(
		input logic [WORD_COUNT_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[lwt_pkg::WNUM_BITS-1:0];
	endfunction

	function automatic lwt_pkg::rec_t mk_rec(
		input logic                          kind,
		input logic [lwt_pkg::LINE_BITS-1:0] line,
		input logic [lwt_pkg::WNUM_BITS-1:0] wnum,
		input logic [OFFSET_BITS-1:0]        start,
		input logic [OFFSET_BITS-1:0]        len);
		lwt_pkg::rec_t r;
		r.kind         = kind;
		r.line_number  = line;
		r.word_number  = wnum;
		r.start_offset = ofs_out(start);
		r.byte_length  = ofs_out(len);
		r.run_last     = 1'b0;
		r.data_end     = 1'b0;
		return r;
	endfunction

	// tokenizer state
	logic [OFFSET_BITS-1:0]        byte_offset_q;
	logic [OFFSET_BITS-1:0]        line_start_q;
	logic [lwt_pkg::LINE_BITS-1:0] line_count_q;
	logic [WORD_COUNT_BITS-1:0]    words_in_line_q;
	logic [OFFSET_BITS-1:0]        word_start_q;
	logic                          inside_word_q;
	brk_t                          pending_q;
	logic                          done_q;

	// next state
	logic [OFFSET_BITS-1:0]        off_d;
	logic [OFFSET_BITS-1:0]        ls_d;
	logic [lwt_pkg::LINE_BITS-1:0] lc_d;
	logic [WORD_COUNT_BITS-1:0]    wil_d;
	logic [OFFSET_BITS-1:0]        ws_d;
	logic                          iw_d;
	brk_t                          pend_d;
	logic                          done_d;

	logic [OFFSET_BITS-1:0] pos;
	logic [OFFSET_BITS-1:0] nxt;
	logic                   words;
	logic                   is_brk;
	logic                   is_sep;
	logic [7:0]             prev_ch;
	logic                   fin;
	logic [1:0]             n;
	lwt_pkg::rec_t          r_d [lwt_pkg::MAX_RECS];

	assign pos      = byte_offset_q;
	assign nxt      = byte_offset_q + OFFSET_BITS'(1);
	assign words    = split_mode;
	assign is_brk   = (data_byte == CH_CR) || (data_byte == CH_LF);
	assign is_sep   = (data_byte == CH_SP) || (data_byte == CH_TAB) ||
			(data_byte == CH_VT) || (data_byte == CH_FF);
	assign prev_ch  = (pending_q == BRK_CR) ? CH_CR : CH_LF;

	// record building and state update for one byte
	always_comb begin
		off_d  = byte_offset_q;
		ls_d   = line_start_q;
		lc_d   = line_count_q;
		wil_d  = words_in_line_q;
		ws_d   = word_start_q;
		iw_d   = inside_word_q;
		pend_d = pending_q;
		done_d = done_q;
		fin    = 1'b0;
		n      = 2'd0;
		for (int i = 0; i < lwt_pkg::MAX_RECS; i++) begin
			r_d[i] = '0;
		end

		if (done_q) begin
			// data already ended by a nul, wait for the buffer end
		end else if (pending_q != BRK_NONE && is_brk && data_byte != prev_ch) begin
			// second byte of a crlf or lfcr pair
			pend_d = BRK_NONE;
			off_d  = nxt;
			ls_d   = nxt;
			if (last_byte) begin
				r_d[0] = mk_rec(lwt_pkg::REC_LINE, lc_d,
						words ? wcnt_out(wil_d) : '0, nxt, '0);
				n   = 2'd1;
				fin = 1'b1;
			end
		end else begin
			pend_d = BRK_NONE;
			iw_d   = words & inside_word_q;

			if (is_brk) begin
				// line break, close any word and the line
				if (iw_d) begin
					r_d[n] = mk_rec(lwt_pkg::REC_WORD, lc_d, wcnt_out(wil_d),
							ws_d, pos - ws_d);
					n = n + 2'd1;
					if (wil_d != WCNT_MAX)
						wil_d = wil_d + WORD_COUNT_BITS'(1);
					iw_d = 1'b0;
				end
				r_d[n] = mk_rec(lwt_pkg::REC_LINE, lc_d,
						words ? wcnt_out(wil_d) : '0, ls_d, pos - ls_d);
				n      = n + 2'd1;
				lc_d   = lc_d + lwt_pkg::LINE_BITS'(1);
				ls_d   = nxt;
				wil_d  = '0;
				iw_d   = 1'b0;
				pend_d = (data_byte == CH_CR) ? BRK_CR : BRK_LF;
				if (last_byte) begin
					r_d[n] = mk_rec(lwt_pkg::REC_LINE, lc_d,
							words ? wcnt_out(wil_d) : '0, ls_d, nxt - ls_d);
					n   = n + 2'd1;
					fin = 1'b1;
				end
			end else if (words && data_byte == CH_NUL) begin
				// nul ends the data in words mode
				if (iw_d) begin
					r_d[n] = mk_rec(lwt_pkg::REC_WORD, lc_d, wcnt_out(wil_d),
							ws_d, pos - ws_d);
					n = n + 2'd1;
					if (wil_d != WCNT_MAX)
						wil_d = wil_d + WORD_COUNT_BITS'(1);
					iw_d = 1'b0;
				end
				r_d[n] = mk_rec(lwt_pkg::REC_LINE, lc_d, wcnt_out(wil_d),
						ls_d, pos - ls_d);
				n      = n + 2'd1;
				fin    = 1'b1;
				done_d = 1'b1;
			end else if (words && is_sep) begin
				// separator closes an open word
				if (iw_d) begin
					r_d[n] = mk_rec(lwt_pkg::REC_WORD, lc_d, wcnt_out(wil_d),
							ws_d, pos - ws_d);
					n = n + 2'd1;
					if (wil_d != WCNT_MAX)
						wil_d = wil_d + WORD_COUNT_BITS'(1);
					iw_d = 1'b0;
				end
				if (last_byte) begin
					r_d[n] = mk_rec(lwt_pkg::REC_LINE, lc_d, wcnt_out(wil_d),
							ls_d, nxt - ls_d);
					n   = n + 2'd1;
					fin = 1'b1;
				end
			end else begin
				// content byte, opens a word in words mode
				if (words && !iw_d) begin
					iw_d = 1'b1;
					ws_d = pos;
				end
				if (last_byte) begin
					if (words && iw_d) begin
						r_d[n] = mk_rec(lwt_pkg::REC_WORD, lc_d, wcnt_out(wil_d),
								ws_d, nxt - ws_d);
						n = n + 2'd1;
						if (wil_d != WCNT_MAX)
							wil_d = wil_d + WORD_COUNT_BITS'(1);
						iw_d = 1'b0;
					end
					r_d[n] = mk_rec(lwt_pkg::REC_LINE, lc_d,
							words ? wcnt_out(wil_d) : '0, ls_d, nxt - ls_d);
					n   = n + 2'd1;
					fin = 1'b1;
				end
			end
			off_d = nxt;
		end

		// flags on the final record of this byte
		if (n != 2'd0) begin
			r_d[n - 2'd1].run_last = 1'b1;
			r_d[n - 2'd1].data_end = fin;
		end

		// buffer end returns everything to the start
		if (last_byte) begin
			off_d  = '0;
			ls_d   = '0;
			lc_d   = '0;
			wil_d  = '0;
			ws_d   = '0;
			iw_d   = 1'b0;
			pend_d = BRK_NONE;
			done_d = 1'b0;
		end
	end

	assign rec_cnt = n;
	assign recs    = r_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q   <= '0;
			line_start_q    <= '0;
			line_count_q    <= '0;
			words_in_line_q <= '0;
			word_start_q    <= '0;
			inside_word_q   <= 1'b0;
			pending_q       <= BRK_NONE;
			done_q          <= 1'b0;
		end else if (step) begin
			byte_offset_q   <= off_d;
			line_start_q    <= ls_d;
			line_count_q    <= lc_d;
			words_in_line_q <= wil_d;
			word_start_q    <= ws_d;
			inside_word_q   <= iw_d;
			pending_q       <= pend_d;
			done_q          <= done_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lwt_rec_fifo.sv =====
// lwt_rec_fifo: result queue taking up to three records a cycle, giving one
// depends on lwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lwt_rec_fifo (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic [1:0] wr_cnt,
	input  lwt_pkg::rec_t wr_recs [lwt_pkg::MAX_RECS],
	output logic          room,
	output logic          rd_valid,
	input  wire logic     rd_ready,
	output lwt_pkg::rec_t rd_rec
);

	lwt_pkg::rec_t                      mem_q [lwt_pkg::QUEUE_DEPTH];
	logic [lwt_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [lwt_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [lwt_pkg::QUEUE_CNT_BITS-1:0] count_q;
	logic                               pop;

	// space for the most records one byte can give
	assign room     = count_q <= lwt_pkg::QUEUE_CNT_BITS'(lwt_pkg::QUEUE_DEPTH -
			lwt_pkg::MAX_RECS);
	assign rd_valid = count_q != '0;
	assign rd_rec   = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;

	// record storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < lwt_pkg::MAX_RECS; i++) begin
			if (2'(i) < wr_cnt)
				mem_q[wr_ptr_q + lwt_pkg::QUEUE_PTR_BITS'(i)] <= wr_recs[i];
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lwt_pkg::QUEUE_PTR_BITS'(wr_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + lwt_pkg::QUEUE_PTR_BITS'(1);
			count_q <= count_q + lwt_pkg::QUEUE_CNT_BITS'(wr_cnt) -
					lwt_pkg::QUEUE_CNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/line_word_tokenizer.sv =====
// Line and word tokenizer. Takes one text byte per item on the slave stream
// (tlast marks the final byte of a buffer) and gives line records, and in
// words mode also word records, on the master stream. A byte is taken into
// an input register and handled, once the queue has space, by one pass of shallow
// classification logic against the tokenizer state; its records (none to
// three) go into an eight-entry queue. The block takes one byte per cycle as
// long as the queue has space for three records and the output side keeps
// draining at one record per cycle; a byte's records pass the input register
// and the queue. Configuration (cfg_we, cfg_wdata: 0 lines, 1 words) must be
// written by the user between buffers with the block idle; the block does not enforce it.
// depends on lwt_pkg, lwt_core, lwt_rec_fifo
`timescale 1ns / 1ps
`default_nettype none

module line_word_tokenizer #(
	parameter int OFFSET_BITS     = 24,
	parameter int WORD_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,     // split_mode
	// byte input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tlast,  // last_byte
	// record output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// line_number[23:0], word_number[39:24], start_offset[63:40],
	// byte_length[87:64], run_last[88], zero[95:89]
	output logic [95:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // record_kind
	output logic             m_axis_tlast   // data_end
);

	logic          split_mode_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic          room;
	logic          step;
	logic [1:0]    rec_cnt;
	lwt_pkg::rec_t recs [lwt_pkg::MAX_RECS];
	lwt_pkg::rec_t out_rec;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_mode_q <= 1'b0;
		end else if (cfg_we) begin
			split_mode_q <= cfg_wdata;
		end
	end

	// input register, handled when the queue has space
	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	lwt_core #(
		.OFFSET_BITS     (OFFSET_BITS),
		.WORD_COUNT_BITS (WORD_COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.split_mode (split_mode_q),
		.rec_cnt    (rec_cnt),
		.recs       (recs)
	);

	lwt_rec_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (step ? rec_cnt : 2'd0),
		.wr_recs  (recs),
		.room     (room),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_rec   (out_rec)
	);

	// output packing
	assign m_axis_tdata = {7'b0, out_rec.run_last, out_rec.byte_length,
			out_rec.start_offset, out_rec.word_number, out_rec.line_number};
	assign m_axis_tuser = out_rec.kind;
	assign m_axis_tlast = out_rec.data_end;

endmodule

`default_nettype wire

// ===== hw/rtl/lwt_checker.sv =====
// lwt_port_checker: port-level checks on the tokenizer record stream
// depends on line_word_tokenizer ports only, bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module lwt_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// a stalled record holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("record changed while stalled");

	// the buffer end is the last record of its byte
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[88])
		else $error("data end without run last");

	// the buffer always closes with a line record
	a_end_line: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
		else $error("word record marked as data end");

	// padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
			m_axis_tvalid |-> m_axis_tdata[95:89] == 7'b0)
		else $error("nonzero padding in record");

endmodule

bind line_word_tokenizer lwt_port_checker u_lwt_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/lwt_checker.sv =====
// lwt_checker: watches the configuration, byte and record channels of the tokenizer,
// keeps its own line and word state and checks every record against its prediction
// depends on lwt_pkg (record type, record kinds)
`timescale 1ns / 1ps

module lwt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          records_owed,
	output int          bytes_seen,
	output int          buffers_seen,
	output int          line_recs_seen,
	output int          word_recs_seen
);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {
		BRK_NONE = 2'd0,
		BRK_CR   = 2'd1,
		BRK_LF   = 2'd2
	} brk_t;

	// tokenizer state as predicted from the accepted bytes
	logic [lwt_pkg::OFS_BITS-1:0]  ofs;
	logic [lwt_pkg::OFS_BITS-1:0]  line_base;
	logic [lwt_pkg::LINE_BITS-1:0] line_idx;
	logic [lwt_pkg::WNUM_BITS-1:0] word_cnt;
	logic [lwt_pkg::OFS_BITS-1:0]  word_base;
	logic                          in_word;
	brk_t                          pend;
	logic                          done;
	logic                          words_mode;

	// records owed by the block, oldest first, and those of the current byte
	lwt_pkg::rec_t owed[$];
	lwt_pkg::rec_t fresh[$];

	int n_bad;
	int n_bytes;
	int n_bufs;
	int n_lines;
	int n_words;

	function automatic string show(lwt_pkg::rec_t r);
		return $sformatf("kind=%0d line=%0d word=%0d start=%0d len=%0d run_last=%0d end=%0d",
			r.kind, r.line_number, r.word_number, r.start_offset, r.byte_length,
			r.run_last, r.data_end);
	endfunction

	task automatic clear_tokens();
		ofs = '0;
		line_base = '0;
		line_idx = '0;
		word_cnt = '0;
		word_base = '0;
		in_word = 1'b0;
		pend = BRK_NONE;
		done = 1'b0;
	endtask

	task automatic add_rec(input logic kind, input logic [lwt_pkg::WNUM_BITS-1:0] wnum,
			input logic [lwt_pkg::OFS_BITS-1:0] base,
			input logic [lwt_pkg::OFS_BITS-1:0] stop);
		lwt_pkg::rec_t r;
		r = '0;
		r.kind = kind;
		r.line_number = line_idx;
		r.word_number = wnum;
		r.start_offset = base;
		r.byte_length = stop - base;
		fresh.push_back(r);
	endtask

	// word record, index saturates at all ones
	task automatic add_word(input logic [lwt_pkg::OFS_BITS-1:0] stop);
		add_rec(lwt_pkg::REC_WORD, word_cnt, word_base, stop);
		if (word_cnt != '1) begin
			word_cnt = word_cnt + lwt_pkg::WNUM_BITS'(1);
		end
		in_word = 1'b0;
	endtask

	task automatic add_line(input logic [lwt_pkg::OFS_BITS-1:0] stop);
		add_rec(lwt_pkg::REC_LINE, words_mode ? word_cnt : '0, line_base, stop);
	endtask

	// predicted records of one byte, appended to the owed queue
	task automatic tokenize(input logic [7:0] b, input logic last);
		logic [lwt_pkg::OFS_BITS-1:0] pos;
		logic [lwt_pkg::OFS_BITS-1:0] nxt;
		logic                         is_brk;
		logic                         is_gap;
		logic                         fin;
		logic                         absorbed;
		lwt_pkg::rec_t                tail;
		pos = ofs;
		nxt = ofs + lwt_pkg::OFS_BITS'(1);
		is_brk = (b == CH_CR) || (b == CH_LF);
		is_gap = (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
		fin = 1'b0;
		absorbed = 1'b0;
		fresh.delete();
		if (done) begin
			// bytes after a nul are dropped up to the end of the buffer
			if (last) begin
				clear_tokens();
			end
		end else begin
			// second half of a crlf or lfcr pair joins the earlier break
			if (pend != BRK_NONE && is_brk && b != (pend == BRK_CR ? CH_CR : CH_LF)) begin
				absorbed = 1'b1;
			end
			pend = BRK_NONE;
			if (absorbed) begin
				ofs = nxt;
				line_base = nxt;
				if (last) begin
					add_line(nxt);
					fin = 1'b1;
				end
			end else begin
				if (!words_mode) begin
					in_word = 1'b0;
				end
				if (is_brk) begin
					if (words_mode && in_word) begin
						add_word(pos);
					end
					add_line(pos);
					line_idx = line_idx + lwt_pkg::LINE_BITS'(1);
					line_base = nxt;
					word_cnt = '0;
					in_word = 1'b0;
					pend = (b == CH_CR) ? BRK_CR : BRK_LF;
					if (last) begin
						add_line(nxt);
						fin = 1'b1;
					end
				end else if (words_mode && b == CH_NUL) begin
					if (in_word) begin
						add_word(pos);
					end
					add_line(pos);
					fin = 1'b1;
					done = 1'b1;
				end else if (words_mode && is_gap) begin
					if (in_word) begin
						add_word(pos);
					end
					if (last) begin
						add_line(nxt);
						fin = 1'b1;
					end
				end else begin
					if (words_mode && !in_word) begin
						in_word = 1'b1;
						word_base = pos;
					end
					if (last) begin
						if (words_mode && in_word) begin
							add_word(nxt);
						end
						add_line(nxt);
						fin = 1'b1;
					end
				end
				ofs = nxt;
			end
			// mark the closing record of this byte
			if (fresh.size() > 0) begin
				tail = fresh.pop_back();
				tail.run_last = 1'b1;
				tail.data_end = fin;
				fresh.push_back(tail);
			end
			if (last) begin
				clear_tokens();
			end
		end
		foreach (fresh[i]) begin
			owed.push_back(fresh[i]);
		end
	endtask

	task automatic report(input string what, input string detail);
		if (n_bad < REPORT_MAX) begin
			$display("%0t mismatch: %s: %s", $realtime, what, detail);
		end
		n_bad++;
	endtask

	// watch all channels at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		lwt_pkg::rec_t got;
		lwt_pkg::rec_t want;
		logic [6:0]    pad;
		if (!arst_n) begin
			words_mode = 1'b0;
			clear_tokens();
			owed.delete();
			n_bad = 0;
			n_bytes = 0;
			n_bufs = 0;
			n_lines = 0;
			n_words = 0;
			mismatches <= 0;
			records_owed <= 0;
			bytes_seen <= 0;
			buffers_seen <= 0;
			line_recs_seen <= 0;
			word_recs_seen <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				tokenize(s_axis_tdata, s_axis_tlast);
				n_bytes++;
				if (s_axis_tlast) begin
					n_bufs++;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.line_number = m_axis_tdata[23:0];
				got.word_number = m_axis_tdata[39:24];
				got.start_offset = m_axis_tdata[63:40];
				got.byte_length = m_axis_tdata[87:64];
				got.run_last = m_axis_tdata[88];
				got.data_end = m_axis_tlast;
				pad = m_axis_tdata[95:89];
				if (got.kind == lwt_pkg::REC_WORD) begin
					n_words++;
				end else begin
					n_lines++;
				end
				if (owed.size() == 0) begin
					report("record with none expected", show(got));
				end else begin
					want = owed.pop_front();
					if (got !== want || pad !== '0) begin
						report("record differs", $sformatf("expected %s | got %s pad=%0h",
							show(want), show(got), pad));
					end
				end
			end
			if (cfg_we) begin
				words_mode = cfg_wdata;
			end
			mismatches <= n_bad;
			records_owed <= owed.size();
			bytes_seen <= n_bytes;
			buffers_seen <= n_bufs;
			line_recs_seen <= n_lines;
			word_recs_seen <= n_words;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: drives text bytes into line_word_tokenizer in both split modes and
// gives the verdict from the mismatch and owed-record counts of lwt_checker
// depends on lwt_pkg, line_word_tokenizer, lwt_checker
`timescale 1ns / 1ps

module tb_top;

	localparam logic MODE_LINES = 1'b0;
	localparam logic MODE_WORDS = 1'b1;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam int RUN_LIMIT     = 2_000_000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 66;
	localparam int N_PHASES      = 6;
	localparam int IDLE_PCT      = 37;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;   // line_number, word_number, start_offset, byte_length, run_last
	logic        m_axis_tuser;   // record_kind
	logic        m_axis_tlast;   // data_end

	int mismatches;
	int records_owed;
	int bytes_seen;
	int buffers_seen;
	int line_recs_seen;
	int word_recs_seen;

	int   cycle_cnt = 0;
	int   tx_idle_pct = IDLE_PCT;
	int   rx_idle_pct = IDLE_PCT;
	bit   hold_req = 1'b0;
	bit   hold_done = 1'b0;
	int   buf_left = 0;
	logic [7:0] prev_byte = '0;

	line_word_tokenizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	lwt_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.records_owed   (records_owed),
		.bytes_seen     (bytes_seen),
		.buffers_seen   (buffers_seen),
		.line_recs_seen (line_recs_seen),
		.word_recs_seen (word_recs_seen)
	);

	// clock
	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d records still owed",
				cycle_cnt, records_owed);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// record side: random stalls and one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// offer one byte and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// wait until every owed record has come and the block has gone quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (records_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// text-like byte mix with every separator, breaks, nul and high bytes
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 8'($urandom_range(8'h61, 8'h7A));
		if (r < 57) return CH_SP;
		if (r < 60) return CH_TAB;
		if (r < 62) return CH_VT;
		if (r < 64) return CH_FF;
		if (r < 72) return CH_LF;
		if (r < 80) return CH_CR;
		if (r < 82) return CH_NUL;
		if (r < 90) return 8'($urandom_range(128, 255));
		return 8'($urandom_range(255));
	endfunction

	// buffers of random length; a buffer may run on into the next phase
	task automatic random_phase(input int n_items);
		logic [7:0] b;
		for (int k = 0; k < n_items; k++) begin
			if (buf_left == 0) begin
				buf_left = ($urandom_range(9) == 0) ?
					$urandom_range(40, 80) : $urandom_range(1, 20);
			end
			buf_left--;
			if (prev_byte == CH_CR && $urandom_range(1) == 1) begin
				b = CH_LF;
			end else begin
				b = pick_text_byte();
			end
			prev_byte = b;
			send_byte(b, buf_left == 0);
		end
	endtask

	logic [7:0] lines_text [9] = '{CH_NUL, 8'hFF, CH_CR, CH_LF, CH_LF, CH_LF, CH_CR, CH_CR,
		CH_LF};
	logic [7:0] words_text [15] = '{CH_SP, 8'h61, 8'h62, CH_TAB, 8'h80, CH_VT, 8'h63, CH_FF,
		8'h64, CH_CR, CH_CR, 8'h65, CH_NUL, 8'h78, 8'h79};
	logic phase_mode [N_PHASES] = '{MODE_WORDS, MODE_LINES, MODE_WORDS, MODE_LINES,
		MODE_WORDS, MODE_WORDS};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lines mode: nul and high byte as content, crlf, lflf, lfcr, absorbed last byte
		set_mode(MODE_LINES);
		foreach (lines_text[i]) begin
			send_byte(lines_text[i], i == $size(lines_text) - 1);
		end
		settle();

		// words mode: every separator, high byte, crcr, nul ending the data
		set_mode(MODE_WORDS);
		foreach (words_text[i]) begin
			send_byte(words_text[i], i == $size(words_text) - 1);
		end
		settle();

		// random text, modes switched between phases, often inside a buffer
		hold_req = 1'b1;
		for (int p = 0; p < N_PHASES; p++) begin
			set_mode(phase_mode[p]);
			tx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
			rx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
			random_phase(PHASE_ITEMS);
			settle();
		end

		$display("covered %0d bytes in %0d buffers: %0d line and %0d word records checked",
			bytes_seen, buffers_seen, line_recs_seen, word_recs_seen);
		$display("both split modes, mid-buffer mode switches, output hold-off, break pairs");
		if (records_owed != 0) begin
			$display("%0d expected records never arrived", records_owed);
		end
		if (mismatches == 0 && records_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
